@@ rtl/gwm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher package
// Shared types and constants for the glob matcher: word kinds, wildcard
// byte codes, pattern store size and the control word sent to each cell.
// ----------------------------------------------------------------------------
package gwm_pkg;

   localparam int PATTERN_CAPACITY = 64;

   localparam logic [7:0] BYTE_STAR = 8'h2A;
   localparam logic [7:0] BYTE_ANY  = 8'h3F;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_NAME   = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef struct packed {
      logic       restart;
      logic       step;
      logic       append;
      logic [7:0] char_byte;
   } cell_ctl_type;

endpackage

@@ rtl/gwm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher channels
// Valid/ready channels for the request words (pattern and name bytes) and
// the response words (match result).
// ----------------------------------------------------------------------------
interface gwm_req_if;
   logic               valid;
   logic               ready;
   gwm_pkg::kind_type  kind;
   logic [7:0]         char_byte;

   modport source (output valid, output kind, output char_byte, input ready);
   modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

interface gwm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic pattern_overflow;

   modport source (output valid, output matched, output pattern_overflow, input ready);
   modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

@@ rtl/gwm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob matcher pattern cell
// Holds one pattern byte and the raw activity bit of its position, and
// hands activity to the next cell when a name byte matches.
// ----------------------------------------------------------------------------
module gwm_cell #(
   parameter int INDEX = 0,
   parameter int LEN_W = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gwm_pkg::cell_ctl_type ctl,
   input  logic [LEN_W-1:0]      length,
   input  logic                  adv_in,
   input  logic                  act_in,
   output logic                  raw_out,
   output logic                  prop_out,
   output logic                  adv_out
);
   import gwm_pkg::*;

   logic [7:0] byte_ff;
   logic       raw_ff;
   logic       raw_in;
   logic       valid;
   logic       star;
   logic       hit;

   assign valid    = length > LEN_W'(INDEX);
   assign star     = byte_ff == BYTE_STAR;
   assign hit      = (byte_ff == BYTE_ANY) || (byte_ff == ctl.char_byte);
   assign prop_out = valid && star;
   assign adv_out  = act_in && valid && !star && hit;
   assign raw_out  = raw_ff;

   always_comb begin
      if (ctl.restart) begin
         raw_in = (INDEX == 0);
      end else if (ctl.step) begin
         raw_in = (act_in && prop_out) || adv_in;
      end else begin
         raw_in = raw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff <= (INDEX == 0);
      end else begin
         raw_ff <= raw_in;
      end
      if (ctl.append && (length == LEN_W'(INDEX))) begin
         byte_ff <= ctl.char_byte;
      end
   end

endmodule

@@ rtl/gwm_closure.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob matcher star closure
// Spreads activity forward across runs of stars. The spread is the carry
// chain of one wide add: stars propagate, active stars generate.
// ----------------------------------------------------------------------------
module gwm_closure #(
   parameter int WIDTH = 65
) (
   input  logic [WIDTH-1:0] raw,
   input  logic [WIDTH-1:0] prop,
   output logic [WIDTH-1:0] closed
);
   import gwm_pkg::*;

   logic [WIDTH-1:0] gen;
   logic [WIDTH:0]   sum;
   logic [WIDTH:0]   carry;

   assign gen    = raw & prop;
   assign sum    = {1'b0, prop} + {1'b0, gen};
   assign carry  = sum ^ {1'b0, prop} ^ {1'b0, gen};
   assign closed = raw | carry[WIDTH-1:0];

endmodule

@@ rtl/glob_wildcard_matcher.sv @@
`timescale 1ns / 1ps
// A response word appears in the cycle after its end-of-name word is accepted.
// Throughput: one request word per cycle while no response word waits unread;
// every cell and the star closure update at once; the response register lets words flow on.
// Reset clears the pattern length and overflow flag and activates position
// zero; pattern bytes are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Glob wildcard matcher
// Matches streamed name bytes against a stored pattern with '*' and '?'
// using a row of pattern cells and an active position set.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher #(
   parameter int PATTERN_CAPACITY = gwm_pkg::PATTERN_CAPACITY
) (
   input logic       clock,
   input logic       reset,
   gwm_req_if.sink   req,
   gwm_rsp_if.source rsp
);
   import gwm_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_CAPACITY + 1);
   localparam int NPOS  = PATTERN_CAPACITY + 1;

   cell_ctl_type     ctl;
   logic             accept;
   logic             full;
   logic [LEN_W-1:0] length_ff, length_in;
   logic             overflow_ff, overflow_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             matched_ff, matched_in;
   logic             rsp_ovf_ff, rsp_ovf_in;
   logic             last_ff, last_in;
   logic [NPOS-1:0]  raw;
   logic [NPOS-1:0]  prop;
   logic [NPOS-1:0]  closed;
   logic [NPOS-1:0]  adv;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign full      = length_ff == LEN_W'(PATTERN_CAPACITY);

   assign ctl.restart   = accept && (req.kind != KIND_NAME);
   assign ctl.step      = accept && (req.kind == KIND_NAME);
   assign ctl.append    = accept && (req.kind == KIND_APPEND) && !full;
   assign ctl.char_byte = req.char_byte;

   assign adv[0] = 1'b0;

   for (genvar i = 0; i < PATTERN_CAPACITY; i++) begin : g_cell
      gwm_cell #(
         .INDEX (i),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .length   (length_ff),
         .adv_in   (adv[i]),
         .act_in   (closed[i]),
         .raw_out  (raw[i]),
         .prop_out (prop[i]),
         .adv_out  (adv[i+1])
      );
   end

   assign raw[PATTERN_CAPACITY]  = last_ff;
   assign prop[PATTERN_CAPACITY] = 1'b0;

   gwm_closure #(
      .WIDTH (NPOS)
   ) u_closure (
      .raw    (raw),
      .prop   (prop),
      .closed (closed)
   );

   always_comb begin
      length_in    = length_ff;
      overflow_in  = overflow_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      matched_in   = matched_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (ctl.restart) begin
         last_in = 1'b0;
      end else if (ctl.step) begin
         last_in = adv[PATTERN_CAPACITY];
      end
      if (accept) begin
         case (req.kind)
            KIND_CLEAR: begin
               length_in   = '0;
               overflow_in = 1'b0;
            end
            KIND_APPEND: begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  length_in = length_ff + LEN_W'(1);
               end
            end
            KIND_END: begin
               rsp_valid_in = 1'b1;
               matched_in   = !overflow_ff && closed[length_ff];
               rsp_ovf_in   = overflow_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         overflow_ff  <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         overflow_ff  <= overflow_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      matched_ff <= matched_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.matched          = matched_ff;
   assign rsp.pattern_overflow = rsp_ovf_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && (req.kind == KIND_END)))
      else $error("Response word without an end-of-name word.");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> full)
      else $error("Overflow flag set with a partly filled pattern store.");

   a_ovf_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(matched_ff && rsp_ovf_ff))
      else $error("Match reported together with pattern overflow.");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      ctl.restart |=> (raw[0] && !last_ff))
      else $error("Active set not restarted at position zero.");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher testbench
// Streams pattern and name words into the matcher through its request
// channel and checks every response word against a scoreboard that keeps
// its own pattern store and active position set. A short directed run
// covers empty names, stars only, zero bytes and pattern changes within a
// name. Random runs then load patterns and send names derived from them,
// some matching and some mutated, with full and overflowing patterns. Both
// channels idle at random, the receiver holds off once for a long stretch,
// and the sender drains once.
// ----------------------------------------------------------------------------
import gwm_pkg::*;

class glob_match_board;
   typedef struct {
      logic matched;
      logic overflow;
   } verdict_type;

   logic [7:0]  pat_store[PATTERN_CAPACITY];
   int unsigned pat_len;
   bit          overflow;
   bit          live[PATTERN_CAPACITY + 1];
   verdict_type awaited[$];
   int          errors;
   int          names;
   int          hits;
   int          ovf_seen;

   function new();
      foreach (pat_store[i]) pat_store[i] = 8'h00;
      pat_len  = 0;
      overflow = 1'b0;
      errors   = 0;
      names    = 0;
      hits     = 0;
      ovf_seen = 0;
      restart();
   endfunction

   // A star may match an empty run, so activity flows across it.
   function void spread_stars();
      for (int i = 0; i < pat_len; i++) begin
         if (live[i] && pat_store[i] == BYTE_STAR) begin
            live[i + 1] = 1'b1;
         end
      end
   endfunction

   function void restart();
      foreach (live[i]) live[i] = 1'b0;
      live[0] = 1'b1;
      spread_stars();
   endfunction

   function void advance(logic [7:0] c);
      bit nxt[PATTERN_CAPACITY + 1];
      foreach (nxt[i]) nxt[i] = 1'b0;
      for (int i = 0; i < pat_len; i++) begin
         if (live[i]) begin
            if (pat_store[i] == BYTE_STAR) begin
               nxt[i] = 1'b1;
            end else if (pat_store[i] == BYTE_ANY || pat_store[i] == c) begin
               nxt[i + 1] = 1'b1;
            end
         end
      end
      live = nxt;
      spread_stars();
   endfunction

   function void note_word(kind_type k, logic [7:0] c);
      verdict_type v;
      case (k)
         KIND_CLEAR: begin
            pat_len  = 0;
            overflow = 1'b0;
            restart();
         end
         KIND_APPEND: begin
            if (pat_len < PATTERN_CAPACITY) begin
               pat_store[pat_len] = c;
               pat_len++;
            end else begin
               overflow = 1'b1;
            end
            restart();
         end
         KIND_NAME: begin
            advance(c);
         end
         default: begin
            v.matched  = !overflow && live[pat_len];
            v.overflow = overflow;
            awaited.push_back(v);
            names++;
            if (v.matched) hits++;
            if (v.overflow) ovf_seen++;
            restart();
         end
      endcase
   endfunction

   function void check_result(logic matched, logic ovf);
      verdict_type want;
      if (awaited.size() == 0) begin
         errors++;
         $display("%0t: response word with none expected: matched %b overflow %b",
                  $time, matched, ovf);
         return;
      end
      want = awaited.pop_front();
      if (matched !== want.matched) begin
         errors++;
         $display("%0t: matched expected %b actual %b", $time, want.matched, matched);
      end
      if (ovf !== want.overflow) begin
         errors++;
         $display("%0t: pattern_overflow expected %b actual %b",
                  $time, want.overflow, ovf);
      end
   endfunction

   function int pending();
      return awaited.size();
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT = 400000;
   localparam int WORD_TARGET = 1500;
   localparam int CALM_AFTER  = 1300;
   localparam int HOLD_AT     = 500;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_AT    = 900;

   logic clock;
   logic reset;

   gwm_req_if req_bus ();
   gwm_rsp_if rsp_bus ();

   glob_match_board board;
   int cycles;
   int words_sent;
   bit calm;
   bit hold_due;
   bit drained;

   glob_wildcard_matcher dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] pattern_char();
      case ($urandom_range(0, 9))
         0, 1, 2: return "a";
         3:       return "b";
         4, 5:    return BYTE_STAR;
         6, 7:    return BYTE_ANY;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] name_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return "a";
         5, 6:          return "b";
         default:       return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_word(kind_type k, logic [7:0] c);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.kind      = k;
      req_bus.char_byte = c;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_word(k, c);
      words_sent++;
      if (words_sent == HOLD_AT) hold_due = 1'b1;
      if (words_sent >= CALM_AFTER) calm = 1'b1;
      @(negedge clock);
   endtask

   // Builds a name that fits the current pattern, then sometimes spoils it.
   task automatic send_name();
      logic [7:0] nm[$];
      int pick;
      for (int i = 0; i < board.pat_len; i++) begin
         if (board.pat_store[i] == BYTE_STAR) begin
            repeat ($urandom_range(0, 3)) nm.push_back(name_char());
         end else if (board.pat_store[i] == BYTE_ANY) begin
            nm.push_back(8'($urandom_range(0, 255)));
         end else begin
            nm.push_back(board.pat_store[i]);
         end
      end
      if ($urandom_range(0, 2) == 0) begin
         pick = $urandom_range(0, nm.size());
         case ($urandom_range(0, 2))
            0: nm.insert(pick, name_char());
            1: if (pick < nm.size()) nm.delete(pick);
            default: if (pick < nm.size()) nm[pick] = name_char();
         endcase
      end
      foreach (nm[i]) begin
         if ($urandom_range(0, 40) == 0) send_word(KIND_APPEND, pattern_char());
         send_word(KIND_NAME, nm[i]);
      end
      send_word(KIND_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic run_episode(bit force_long);
      int plen;
      if (force_long || $urandom_range(0, 4) != 0) begin
         send_word(KIND_CLEAR, 8'($urandom_range(0, 255)));
      end
      if (force_long) begin
         plen = PATTERN_CAPACITY + 2;
      end else if ($urandom_range(0, 24) == 0) begin
         plen = $urandom_range(PATTERN_CAPACITY - 8, PATTERN_CAPACITY + 6);
      end else begin
         plen = $urandom_range(0, 7);
      end
      repeat (plen) send_word(KIND_APPEND, pattern_char());
      repeat ($urandom_range(1, 5)) begin
         if ($urandom_range(0, 9) == 0) begin
            send_word(kind_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end else begin
            send_name();
         end
      end
   endtask

   initial begin : receiver
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_due) begin
            hold_due      = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_result(rsp_bus.matched, rsp_bus.pattern_overflow);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, board.pending());
         $display("glob_wildcard_matcher regression: fail");
         $finish;
      end
   end

   initial begin : sender
      board             = new();
      cycles            = 0;
      words_sent        = 0;
      calm              = 1'b0;
      hold_due          = 1'b0;
      drained           = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.kind      = KIND_CLEAR;
      req_bus.char_byte = 8'h00;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Empty pattern against an empty name, then against a one-byte name.
      send_word(KIND_END, 8'h00);
      send_word(KIND_NAME, "x");
      send_word(KIND_END, 8'hFF);
      // Stars only: the empty name and a name of extreme bytes both match.
      send_word(KIND_APPEND, BYTE_STAR);
      send_word(KIND_END, 8'h00);
      send_word(KIND_APPEND, BYTE_STAR);
      send_word(KIND_NAME, 8'h00);
      send_word(KIND_NAME, 8'hFF);
      send_word(KIND_END, 8'h00);
      // A zero byte is an ordinary literal in both pattern and name.
      send_word(KIND_CLEAR, 8'hFF);
      send_word(KIND_APPEND, "a");
      send_word(KIND_APPEND, BYTE_ANY);
      send_word(KIND_APPEND, 8'h00);
      send_word(KIND_NAME, "a");
      send_word(KIND_NAME, 8'hFF);
      send_word(KIND_NAME, 8'h00);
      send_word(KIND_END, 8'h55);
      // Appending within a name abandons the name in progress.
      send_word(KIND_NAME, "a");
      send_word(KIND_APPEND, BYTE_STAR);
      send_word(KIND_NAME, "a");
      send_word(KIND_NAME, BYTE_ANY);
      send_word(KIND_NAME, 8'h00);
      send_word(KIND_NAME, "z");
      send_word(KIND_END, 8'hAA);
      send_word(KIND_NAME, "b");
      send_word(KIND_END, 8'h00);

      run_episode(1'b1);
      while (words_sent < WORD_TARGET) begin
         if (!drained && words_sent >= DRAIN_AT) begin
            drained       = 1'b1;
            req_bus.valid = 1'b0;
            while (board.pending() != 0) @(posedge clock);
            @(negedge clock);
         end
         run_episode(1'b0);
      end
      req_bus.valid = 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d request words over %0d cycles and checked %0d names,",
               words_sent, cycles, board.names);
      $display("of which %0d matched and %0d saw an overflowed pattern.",
               board.hits, board.ovf_seen);
      if (board.errors == 0) begin
         $display("glob_wildcard_matcher regression: pass");
      end else begin
         $display("glob_wildcard_matcher regression: fail");
      end
      $finish;
   end
endmodule
